// ===== hdl/frp_pkg.sv =====
// ----------------------------------------------------------------------------
// FIFO replacement policy package
// Sizes, request codes, controller states and the command and status
// bundles shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package frp_pkg;

  // Cache geometry.
  localparam int SETS     = 2048;
  localparam int WAYS     = 16;
  localparam int AGE_BITS = 16;

  // Fixed field widths of the request and result ports.
  localparam int SET_IDX_W = 11;
  localparam int WAY_W     = 4;
  localparam int VICTIM_W  = 4;

  // Derived sizes.
  localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_IDX_W = $clog2(WAYS);
  localparam int NODES     = 2 ** WAY_IDX_W;
  localparam int LVL_W     = $clog2(WAY_IDX_W + 1);
  localparam int ROW_W     = WAYS * AGE_BITS;

  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  // Request operation codes.
  localparam logic OP_QUERY  = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_LOAD,
    ST_REDUCE,
    ST_FINISH
  } frp_state_t;

  typedef struct packed {
    logic rd_en;
    logic capture;
    logic clr_en;
    logic wr_en;
    logic cand_load;
    logic reduce;
    logic out_load;
  } frp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic req_update;
    logic req_in_range;
    logic red_last;
    logic out_free;
  } frp_status_t;

endpackage

// ===== hdl/frp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module frp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/frp_ctrl.sv =====
// ----------------------------------------------------------------------------
// FIFO replacement policy controller
// Sequences the clearing pass, the read-modify-write of an update and the
// staged oldest-way search of a query.
// ----------------------------------------------------------------------------
module frp_ctrl import frp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  frp_status_t status,
  output frp_cmd_t    cmd
);

  frp_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (status.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          cmd.rd_en   = 1'b1;
          if (status.req_update) begin
            state_next = status.req_in_range ? ST_WRITE : ST_IDLE;
          end else begin
            state_next = status.req_in_range ? ST_LOAD : ST_FINISH;
          end
        end
      end
      ST_WRITE: begin
        cmd.wr_en  = 1'b1;
        state_next = ST_IDLE;
      end
      ST_LOAD: begin
        cmd.cand_load = 1'b1;
        state_next    = ST_REDUCE;
      end
      ST_REDUCE: begin
        cmd.reduce = 1'b1;
        if (status.red_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== hdl/frp_datapath.sv =====
// ----------------------------------------------------------------------------
// FIFO replacement policy datapath
// Age memory, request capture, saturating row update, halving search tree
// and the result register.
// ----------------------------------------------------------------------------
module frp_datapath import frp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 operation,
  input  logic [SET_IDX_W-1:0] set_index,
  input  logic [WAY_W-1:0]     way,
  input  logic                 hit,
  input  logic                 rsp_ready,
  output logic                 rsp_valid,
  output logic [VICTIM_W-1:0]  victim_way,
  input  frp_cmd_t             cmd,
  output frp_status_t          status
);

  logic [SET_W+SET_IDX_W-1:0] set_ext;
  logic [SET_W-1:0]           req_addr;
  logic [SET_W-1:0]           row_addr;
  logic [SET_W-1:0]           clr_cnt;
  logic [WAY_W-1:0]           way_q;
  logic                       hit_q;
  logic                       in_range_q;
  logic                       req_in_range;

  logic                       ram_we;
  logic [SET_W-1:0]           ram_waddr;
  logic [ROW_W-1:0]           ram_wdata;
  logic [ROW_W-1:0]           ram_rdata;
  logic [ROW_W-1:0]           new_row;

  logic [AGE_BITS-1:0]        cand_age [NODES];
  logic [WAY_IDX_W-1:0]       cand_idx [NODES];
  logic [LVL_W-1:0]           lvl;
  logic [WAY_IDX_W+VICTIM_W-1:0] victim_ext;

  assign set_ext      = {{SET_W{1'b0}}, set_index};
  assign req_addr     = set_ext[SET_W-1:0];
  assign req_in_range = 32'(set_index) < SETS;

  assign status.clr_last     = clr_cnt == SET_W'(SETS - 1);
  assign status.req_update   = operation == OP_UPDATE;
  assign status.req_in_range = req_in_range;
  assign status.red_last     = lvl == LVL_W'(WAY_IDX_W - 1);
  assign status.out_free     = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_addr   <= req_addr;
      way_q      <= way;
      hit_q      <= hit;
      in_range_q <= req_in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Every way ages by one, saturating; a fill then restarts its own way.
  always_comb begin
    logic [AGE_BITS-1:0] age_i;
    new_row = '0;
    for (int i = 0; i < WAYS; i++) begin
      age_i = ram_rdata[i*AGE_BITS +: AGE_BITS];
      if (!hit_q && (32'(way_q) == i)) begin
        new_row[i*AGE_BITS +: AGE_BITS] = '0;
      end else if (age_i == AGE_MAX) begin
        new_row[i*AGE_BITS +: AGE_BITS] = age_i;
      end else begin
        new_row[i*AGE_BITS +: AGE_BITS] = age_i + 1'b1;
      end
    end
  end

  assign ram_we    = cmd.clr_en || cmd.wr_en;
  assign ram_waddr = cmd.clr_en ? clr_cnt : row_addr;
  assign ram_wdata = cmd.clr_en ? '0 : new_row;

  frp_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_age_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (req_addr),
    .rdata (ram_rdata)
  );

  // Each step halves the candidates; the even (lower) way keeps a tie.
  always_ff @(posedge clk) begin
    if (cmd.cand_load) begin
      for (int i = 0; i < NODES; i++) begin
        cand_idx[i] <= WAY_IDX_W'(i);
        if (i < WAYS) begin
          cand_age[i] <= ram_rdata[i*AGE_BITS +: AGE_BITS];
        end else begin
          cand_age[i] <= '0;
        end
      end
    end else if (cmd.reduce) begin
      for (int i = 0; i < NODES / 2; i++) begin
        if (cand_age[2*i+1] > cand_age[2*i]) begin
          cand_age[i] <= cand_age[2*i+1];
          cand_idx[i] <= cand_idx[2*i+1];
        end else begin
          cand_age[i] <= cand_age[2*i];
          cand_idx[i] <= cand_idx[2*i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl <= '0;
    end else if (cmd.cand_load) begin
      lvl <= '0;
    end else if (cmd.reduce) begin
      lvl <= lvl + 1'b1;
    end
  end

  assign victim_ext = {{VICTIM_W{1'b0}}, cand_idx[0]};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      victim_way <= in_range_q ? victim_ext[VICTIM_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

// ===== hdl/fifo_replacement_policy.sv =====
// ----------------------------------------------------------------------------
// FIFO replacement policy
// Update request: the aged row is written back in the cycle after
// acceptance, and no new request is taken before that write. Query request:
// the row is loaded into the halving search tree and reduced, the result is
// registered once the result register is free, and the next request is taken
// in the cycle after that. After reset a clearing pass writes zero to all
// SETS rows and no request is accepted until it ends.
// ----------------------------------------------------------------------------
//
// Every set holds one row of the age memory, one age counter per way. An
// update request reads the row, ages every way by one with saturation,
// restarts the named way on a fill, and writes the row back. A query
// request reads the row and searches it for the oldest way, each step of
// the search halving the candidates, the lower way winning a tie.
// The result register sits between the search and the result channel, so a
// new request can be taken while a finished result still waits.
// A request naming a set beyond the memory answers way zero as a query and
// leaves the ages untouched as an update.
module fifo_replacement_policy import frp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  logic                 operation,
  input  logic [SET_IDX_W-1:0] set_index,
  input  logic [WAY_W-1:0]     way,
  input  logic                 hit,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output logic [VICTIM_W-1:0]  victim_way
);

  frp_cmd_t    cmd;
  frp_status_t status;

  // The controller decides what happens in each cycle; it sees req_valid
  // directly and the rest of the request only through the status bundle.
  frp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the age memory, the search tree and the result
  // register.
  frp_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .operation  (operation),
    .set_index  (set_index),
    .way        (way),
    .hit        (hit),
    .rsp_ready  (rsp_ready),
    .rsp_valid  (rsp_valid),
    .victim_way (victim_way),
    .cmd        (cmd),
    .status     (status)
  );

endmodule
